// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/dwc_pkg.sv -----
package dwc_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_BITS      = 16;
  localparam int SLOT_BITS      = 16;
  localparam int FRAC_BITS      = 8;
  localparam int ROWS           = 5;
  localparam int TAPS_PER_ROW   = 5;
  localparam int KEEP_COLS      = 4;
  localparam int FRAME_COLS     = KEEP_COLS + 1;
  localparam int NUM_COEFS      = 1 + ROWS * TAPS_PER_ROW;
  localparam int COEFS_PER_BANK = 4;
  localparam int NUM_WIDE_BANKS = 6;
  localparam int WIDE_COEFS     = NUM_WIDE_BANKS * COEFS_PER_BANK;
  localparam int BANK_BITS      = COEFS_PER_BANK * SLOT_BITS;
  localparam int TAIL_BITS      = (NUM_COEFS - WIDE_COEFS) * SLOT_BITS;
  localparam int PIX_BITS       = 32;
  localparam int PROD_BITS      = 2 * SLOT_BITS;
  localparam int LANE_BITS      = PROD_BITS + 2;
  localparam int ACC_BITS       = PROD_BITS + 4;
  localparam int CFG_IDX_W      = 3;
  localparam int SEEN_W         = 3;
  localparam int WIN_FILL       = 2;
  localparam int FIFO_DEPTH     = 8;
  localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam int SAMPLE_EFF = (SAMPLE_BITS > SLOT_BITS) ? SLOT_BITS : SAMPLE_BITS;
  localparam int COEF_EFF   = (COEF_BITS > SLOT_BITS) ? SLOT_BITS : COEF_BITS;
  localparam int SAMPLE_SH  = SLOT_BITS - SAMPLE_EFF;
  localparam int COEF_SH    = SLOT_BITS - COEF_EFF;

  localparam logic [1:0] FLUSH_FIRST = 2'd0;
  localparam logic [1:0] FLUSH_MID   = 2'd1;
  localparam logic [1:0] FLUSH_LAST  = 2'd2;

  typedef logic signed [SLOT_BITS-1:0] q88_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [LANE_BITS-1:0] lane_t;
  typedef logic signed [ACC_BITS-1:0]  acc_t;
  typedef logic signed [PIX_BITS-1:0]  pixel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_BANK_0  = 3'd0,
    REG_COEF_BANK_1  = 3'd1,
    REG_COEF_BANK_2  = 3'd2,
    REG_COEF_BANK_3  = 3'd3,
    REG_COEF_BANK_4  = 3'd4,
    REG_COEF_BANK_5  = 3'd5,
    REG_COEF_BANK_6  = 3'd6,
    REG_CLAMP_BOUNDS = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    ST_STREAM,
    ST_FLUSH
  } seq_state_t;

  typedef struct packed {
    logic valid;
    logic run_last;
    logic row_last;
  } tag_t;

  typedef struct packed {
    pixel_t pixel;
    logic   run_last;
    logic   row_last;
  } out_word_t;

  function automatic q88_t sext_sample(input logic [SLOT_BITS-1:0] v);
    logic [SLOT_BITS-1:0] t;
    t = v << SAMPLE_SH;
    return $signed(t) >>> SAMPLE_SH;
  endfunction

  function automatic q88_t sext_coef(input logic [SLOT_BITS-1:0] v);
    logic [SLOT_BITS-1:0] t;
    t = v << COEF_SH;
    return $signed(t) >>> COEF_SH;
  endfunction

endpackage

// ----- sv/dwc_cfg_if.sv -----
interface dwc_cfg_if import dwc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BANK_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/dwc_in_if.sv -----
interface dwc_in_if import dwc_pkg::*; ();
  logic valid;
  logic ready;
  q88_t sample_row0;
  q88_t sample_row1;
  q88_t sample_row2;
  q88_t sample_row3;
  q88_t sample_row4;
  logic row_end;

  modport source (output valid, output sample_row0, output sample_row1, output sample_row2,
                  output sample_row3, output sample_row4, output row_end, input ready);
  modport sink   (input valid, input sample_row0, input sample_row1, input sample_row2,
                  input sample_row3, input sample_row4, input row_end, output ready);
endinterface

// ----- sv/dwc_out_if.sv -----
interface dwc_out_if import dwc_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t pixel_out;
  logic   run_last;
  logic   row_last;

  modport source (output valid, output pixel_out, output run_last, output row_last,
                  input ready);
  modport sink   (input valid, input pixel_out, input run_last, input row_last,
                  output ready);
endinterface

// ----- sv/dwc_lane.sv -----
module dwc_lane import dwc_pkg::*; (
  input  logic  clk,
  input  q88_t  sample [TAPS_PER_ROW],
  input  q88_t  tap    [TAPS_PER_ROW],
  output lane_t lane_sum
);

  prod_t prod [TAPS_PER_ROW];
  lane_t sum_next;

  always_ff @(posedge clk) begin
    for (int k = 0; k < TAPS_PER_ROW; k++) begin
      prod[k] <= sample[k] * tap[k];
    end
  end

  always_comb begin
    sum_next = '0;
    for (int k = 0; k < TAPS_PER_ROW; k++) begin
      sum_next = sum_next + LANE_BITS'(prod[k]);
    end
  end

  always_ff @(posedge clk) begin
    lane_sum <= sum_next;
  end

endmodule

// ----- sv/dwc_merge.sv -----
module dwc_merge import dwc_pkg::*; (
  input  logic   clk,
  input  lane_t  lane_sum [ROWS],
  input  q88_t   bias,
  input  pixel_t clamp_lo,
  input  pixel_t clamp_hi,
  output pixel_t pixel
);

  acc_t acc;
  acc_t acc_next;
  acc_t lo_x;
  acc_t hi_x;
  acc_t clamped;

  always_comb begin
    acc_next = ACC_BITS'(bias) <<< FRAC_BITS;
    for (int r = 0; r < ROWS; r++) begin
      acc_next = acc_next + ACC_BITS'(lane_sum[r]);
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  // raise to min first, then lower to max: max wins on crossed bounds
  always_comb begin
    lo_x    = ACC_BITS'(clamp_lo);
    hi_x    = ACC_BITS'(clamp_hi);
    clamped = acc;
    if (clamped < lo_x) begin
      clamped = lo_x;
    end
    if (clamped > hi_x) begin
      clamped = hi_x;
    end
    pixel = clamped[PIX_BITS-1:0];
  end

endmodule

// ----- sv/dwc_fifo.sv -----
`include "assert_macros.svh"

module dwc_fifo import dwc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  out_word_t        word,
  dwc_out_if.source        src
);

  out_word_t               mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr;
  logic [FIFO_PTR_W-1:0]   rd_ptr;
  logic [FIFO_CNT_W-1:0]   count;
  logic                    pop;

  assign pop       = src.valid && src.ready;
  assign src.valid = (count != '0);
  assign src.pixel_out = mem[rd_ptr].pixel;
  assign src.run_last  = mem[rd_ptr].run_last;
  assign src.row_last  = mem[rd_ptr].row_last;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  `ASSERT_IMPLY(a_fifo_no_overflow, clk, rst, push && !pop, count < FIFO_CNT_W'(FIFO_DEPTH), "dwc_fifo: word pushed into full queue")

endmodule

// ----- sv/depthwise_conv5x5_clamp.sv -----
// channel   dir  handshake    word
// cfg       in   valid/ready  index[2:0], data[63:0]
// columns   in   valid/ready  sample_row0..4 (Q8.8), row_end
// pixels    out  valid/ready  pixel_out (Q16.16), run_last, row_last
//
// One column per cycle; columns.ready drops when all 8 queue credits are taken.
// A row-end column then holds columns.ready low until its flush has issued 1..3 results.
// A result reaches pixels through registered steps in order (sample capture, tap
// multiply, lane add, merge add, queue write). cfg is always ready.
// Synchronous reset clears window, coefficients and queue, and sets clamp bounds to full range.
`include "assert_macros.svh"

module depthwise_conv5x5_clamp import dwc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dwc_cfg_if.sink    cfg,
  dwc_in_if.sink     columns,
  dwc_out_if.source  pixels
);

  logic [BANK_BITS-1:0]   coef_bank [NUM_WIDE_BANKS];
  logic [TAIL_BITS-1:0]   coef_tail;
  logic [2*PIX_BITS-1:0]  clamp_bounds;
  logic [SLOT_BITS-1:0]   coef_raw [NUM_COEFS];
  q88_t                   coef_val [NUM_COEFS];

  q88_t                   win [KEEP_COLS][ROWS];
  q88_t                   new_col [ROWS];
  q88_t                   frame [FRAME_COLS][ROWS];
  q88_t                   flush_frame [FRAME_COLS][ROWS];
  q88_t                   src [FRAME_COLS][ROWS];
  logic [SEEN_W-1:0]      seen;

  seq_state_t             state;
  seq_state_t             state_next;
  logic [1:0]             flush_pos;
  logic [1:0]             flush_pos_next;
  logic [1:0]             start;
  logic                   accept;
  logic                   space;
  logic                   issue;
  logic                   issue_run_last;
  logic                   issue_row_last;

  q88_t                   job_col [ROWS][TAPS_PER_ROW];
  q88_t                   job_smp [ROWS][TAPS_PER_ROW];
  q88_t                   lane_tap [ROWS][TAPS_PER_ROW];
  lane_t                  lane_sum [ROWS];
  tag_t                   tag [4];
  pixel_t                 pixel;
  logic [FIFO_CNT_W-1:0]  used;
  logic                   pop;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_WIDE_BANKS; b++) begin
        coef_bank[b] <= '0;
      end
      coef_tail    <= '0;
      clamp_bounds <= {1'b0, {(PIX_BITS-1){1'b1}}, 1'b1, {(PIX_BITS-1){1'b0}}};
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_COEF_BANK_0, REG_COEF_BANK_1, REG_COEF_BANK_2,
        REG_COEF_BANK_3, REG_COEF_BANK_4, REG_COEF_BANK_5: begin
          coef_bank[cfg.index] <= cfg.data;
        end
        REG_COEF_BANK_6: begin
          coef_tail <= cfg.data[TAIL_BITS-1:0];
        end
        REG_CLAMP_BOUNDS: begin
          clamp_bounds <= cfg.data;
        end
        default: ;
      endcase
    end
  end

  for (genvar gj = 0; gj < NUM_COEFS; gj++) begin : g_coef
    if (gj < WIDE_COEFS) begin : g_wide
      localparam int BANK = gj / COEFS_PER_BANK;
      localparam int SLOT = gj % COEFS_PER_BANK;
      assign coef_raw[gj] = coef_bank[BANK][SLOT*SLOT_BITS +: SLOT_BITS];
    end else begin : g_tail
      assign coef_raw[gj] = coef_tail[(gj-WIDE_COEFS)*SLOT_BITS +: SLOT_BITS];
    end
    assign coef_val[gj] = sext_coef(coef_raw[gj]);
  end

  // column window
  assign new_col[0] = columns.sample_row0;
  assign new_col[1] = columns.sample_row1;
  assign new_col[2] = columns.sample_row2;
  assign new_col[3] = columns.sample_row3;
  assign new_col[4] = columns.sample_row4;

  always_comb begin
    for (int c = 0; c < KEEP_COLS; c++) begin
      frame[c] = win[c];
    end
    frame[KEEP_COLS] = new_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < KEEP_COLS; c++) begin
        for (int r = 0; r < ROWS; r++) begin
          win[c][r] <= '0;
        end
      end
      seen <= '0;
    end else if (accept) begin
      if (columns.row_end) begin
        for (int c = 0; c < KEEP_COLS; c++) begin
          for (int r = 0; r < ROWS; r++) begin
            win[c][r] <= '0;
          end
        end
        seen <= '0;
      end else begin
        for (int c = 0; c < KEEP_COLS - 1; c++) begin
          win[c] <= win[c+1];
        end
        win[KEEP_COLS-1] <= new_col;
        if (seen < SEEN_W'(KEEP_COLS)) begin
          seen <= seen + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && columns.row_end) begin
      flush_frame <= frame;
    end
  end

  // issue sequencer
  assign accept        = columns.valid && columns.ready;
  assign space         = (used < FIFO_CNT_W'(FIFO_DEPTH));
  assign columns.ready = (state == ST_STREAM) && space;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_STREAM;
      flush_pos <= FLUSH_FIRST;
    end else begin
      state     <= state_next;
      flush_pos <= flush_pos_next;
    end
  end

  always_comb begin
    state_next     = state;
    flush_pos_next = flush_pos;
    issue          = 1'b0;
    issue_run_last = 1'b0;
    issue_row_last = 1'b0;
    start          = FLUSH_FIRST;
    case (state)
      ST_STREAM: begin
        issue          = accept && !columns.row_end && (seen >= SEEN_W'(WIN_FILL));
        issue_run_last = 1'b1;
        if (accept && columns.row_end) begin
          state_next = ST_FLUSH;
          if (seen >= SEEN_W'(WIN_FILL)) begin
            flush_pos_next = FLUSH_FIRST;
          end else if (seen == SEEN_W'(1)) begin
            flush_pos_next = FLUSH_MID;
          end else begin
            flush_pos_next = FLUSH_LAST;
          end
        end
      end
      ST_FLUSH: begin
        start          = flush_pos;
        issue          = space;
        issue_run_last = (flush_pos == FLUSH_LAST);
        issue_row_last = (flush_pos == FLUSH_LAST);
        if (space) begin
          if (flush_pos == FLUSH_LAST) begin
            state_next = ST_STREAM;
          end else begin
            flush_pos_next = flush_pos + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_STREAM;
      end
    endcase
  end

  // five-column slice starting at start; columns past the row end read zero
  always_comb begin
    int idx;
    if (state == ST_FLUSH) begin
      src = flush_frame;
    end else begin
      src = frame;
    end
    for (int r = 0; r < ROWS; r++) begin
      for (int k = 0; k < TAPS_PER_ROW; k++) begin
        idx = int'(start) + k;
        job_col[r][k] = (idx < FRAME_COLS) ? src[idx[2:0]][r] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int k = 0; k < TAPS_PER_ROW; k++) begin
          job_smp[r][k] <= sext_sample(job_col[r][k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 4; s++) begin
        tag[s] <= '0;
      end
    end else begin
      tag[0] <= '{valid: issue, run_last: issue_run_last, row_last: issue_row_last};
      for (int s = 1; s < 4; s++) begin
        tag[s] <= tag[s-1];
      end
    end
  end

  // row lanes and merge
  for (genvar gr = 0; gr < ROWS; gr++) begin : g_lane
    for (genvar gk = 0; gk < TAPS_PER_ROW; gk++) begin : g_tap
      assign lane_tap[gr][gk] = coef_val[1 + gr*TAPS_PER_ROW + gk];
    end
    dwc_lane u_lane (
      .clk      (clk),
      .sample   (job_smp[gr]),
      .tap      (lane_tap[gr]),
      .lane_sum (lane_sum[gr])
    );
  end

  dwc_merge u_merge (
    .clk      (clk),
    .lane_sum (lane_sum),
    .bias     (coef_val[0]),
    .clamp_lo (clamp_bounds[PIX_BITS-1:0]),
    .clamp_hi (clamp_bounds[2*PIX_BITS-1:PIX_BITS]),
    .pixel    (pixel)
  );

  // result queue with credit count covering words in flight
  assign pop = pixels.valid && pixels.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used + FIFO_CNT_W'(issue) - FIFO_CNT_W'(pop);
    end
  end

  dwc_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (tag[3].valid),
    .word ('{pixel: pixel, run_last: tag[3].run_last, row_last: tag[3].row_last}),
    .src  (pixels)
  );

  `ASSERT_NEXT(a_row_end_flush, clk, rst, accept && columns.row_end,
               (state == ST_FLUSH) && (seen == '0), "row end did not start flush")
  `ASSERT_NEXT(a_flush_exit, clk, rst, (state == ST_FLUSH) && space && (flush_pos == FLUSH_LAST),
               state == ST_STREAM, "flush did not end after last word")
  `ASSERT_IMPLY(a_row_last_run_last, clk, rst, tag[3].valid && tag[3].row_last,
                tag[3].run_last, "row_last without run_last")

endmodule
